>>> src/sdip_pkg.sv
// sdip_pkg: types, codes and constants shared by the decimal integer parser
// no dependencies; imported by every module under src

package sdip_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_t;

	typedef struct packed {
		logic signed [63:0] parsed_value;
		logic [1:0]         parse_status;
	} res_t;

	typedef enum logic [2:0] {
		CK_WS,
		CK_PLUS,
		CK_MINUS,
		CK_DIGIT,
		CK_STRAY
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       last;
	} cls_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_TRAIL
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_INVALID,
		ST_OVERFLOW
	} status_t;

endpackage

>>> src/sdip_front.sv
// sdip_front: input stage that accepts characters and classifies them
// depends on sdip_pkg; feeds sdip_queue

module sdip_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  sdip_pkg::char_t     data,
	input  logic                q_full,
	output logic                push,
	output sdip_pkg::cls_t      push_data
);
	import sdip_pkg::*;

	logic  valid_s1;
	cls_t  cls_s1;
	cls_t  cls_c;
	logic  [7:0] diff;

	assign diff = data.char_code - CH_ZERO;

	always_comb begin
		cls_c.digit = diff[3:0];
		cls_c.last  = data.last_char;
		if ((data.char_code >= CH_TAB && data.char_code <= CH_CR) ||
		    data.char_code == CH_SPACE) begin
			cls_c.kind = CK_WS;
		end else if (data.char_code == CH_PLUS) begin
			cls_c.kind = CK_PLUS;
		end else if (data.char_code == CH_MINUS) begin
			cls_c.kind = CK_MINUS;
		end else if (data.char_code >= CH_ZERO && data.char_code <= CH_NINE) begin
			cls_c.kind = CK_DIGIT;
		end else begin
			cls_c.kind = CK_STRAY;
		end
	end

	assign stall     = valid_s1 & q_full;
	assign push      = valid_s1 & ~q_full;
	assign push_data = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (valid && !stall) begin
			cls_s1 <= cls_c;
		end
	end

endmodule

>>> src/sdip_queue.sv
// sdip_queue: short queue of classified characters between front and back
// depends on sdip_pkg

module sdip_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sdip_pkg::cls_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sdip_pkg::cls_t  head
);
	import sdip_pkg::*;

	cls_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

>>> src/sdip_back.sv
// sdip_back: scan state machine, magnitude accumulation and result register
// depends on sdip_pkg; drains sdip_queue

module sdip_back #(
	parameter int VALUE_BITS = sdip_pkg::VALUE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sdip_pkg::cls_t  head,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output sdip_pkg::res_t  res_data
);
	import sdip_pkg::*;

	localparam int MW = VALUE_BITS - 1;

	phase_t          phase_q, phase_n;
	logic            neg_q, neg_n;
	logic [MW-1:0]   mag_q, mag_n;
	status_t         err_q, err_n;
	status_t         status_c;
	logic [MW+3:0]   sum;
	logic            ovf;
	logic            out_free;
	logic            take;
	logic            finish;

	logic            res_valid_q;
	logic [MW-1:0]   res_mag_q;
	logic            res_neg_q;
	status_t         res_status_q;
	logic [63:0]     mag64;

	assign out_free = ~res_valid_q | ~res_stall;
	assign take     = head_valid & (~head.last | out_free);
	assign finish   = take & head.last;
	assign pop      = take;

	// multiply by ten and add the digit
	assign sum = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {{MW{1'b0}}, head.digit};
	assign ovf = |sum[MW+3:MW];

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		mag_n   = mag_q;
		err_n   = err_q;
		if (err_q == ST_OK) begin
			unique case (phase_q)
				PH_LEAD: begin
					unique case (head.kind)
						CK_WS: ;
						CK_PLUS, CK_MINUS: begin
							neg_n   = (head.kind == CK_MINUS);
							phase_n = PH_SIGN;
						end
						CK_DIGIT: begin
							phase_n = PH_DIGITS;
							if (ovf) err_n = ST_OVERFLOW;
							else     mag_n = sum[MW-1:0];
						end
						default: err_n = ST_INVALID;
					endcase
				end
				PH_SIGN: begin
					if (head.kind == CK_DIGIT) begin
						phase_n = PH_DIGITS;
						if (ovf) err_n = ST_OVERFLOW;
						else     mag_n = sum[MW-1:0];
					end else begin
						err_n = ST_INVALID;
					end
				end
				PH_DIGITS: begin
					if (head.kind == CK_DIGIT) begin
						if (ovf) err_n = ST_OVERFLOW;
						else     mag_n = sum[MW-1:0];
					end else if (head.kind == CK_WS) begin
						phase_n = PH_TRAIL;
					end else begin
						err_n = ST_INVALID;
					end
				end
				PH_TRAIL: begin
					if (head.kind != CK_WS) err_n = ST_INVALID;
				end
				default: ;
			endcase
		end

		if (err_n != ST_OK)          status_c = err_n;
		else if (phase_n == PH_LEAD) status_c = ST_EMPTY;
		else if (phase_n == PH_SIGN) status_c = ST_INVALID;
		else                         status_c = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			err_q   <= ST_OK;
		end else if (finish) begin
			phase_q <= PH_LEAD;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			err_q   <= ST_OK;
		end else if (take) begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			mag_q   <= mag_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_status_q <= status_c;
			res_neg_q    <= neg_n & (status_c == ST_OK);
			res_mag_q    <= (status_c == ST_OK) ? mag_n : '0;
		end
	end

	assign mag64                 = {{(64-MW){1'b0}}, res_mag_q};
	assign res_valid             = res_valid_q;
	assign res_data.parsed_value = res_neg_q ? -mag64 : mag64;
	assign res_data.parse_status = res_status_q;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (phase_q == PH_LEAD && err_q == ST_OK && mag_q == '0 && !neg_q))
		else $error("scan state not cleared after last character");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK && !finish) |=> $stable(err_q) && $stable(mag_q))
		else $error("latched error changed before string end");

	a_trail_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRAIL && !finish) |=> phase_q == PH_TRAIL)
		else $error("left trailing whitespace phase mid string");

	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (!res_valid_q || !res_stall))
		else $error("result overwritten while held");

endmodule

>>> src/strict_decimal_integer_parser.sv
// strict_decimal_integer_parser: top level of the ascii decimal to int64 parser
// depends on sdip_pkg, sdip_front, sdip_queue, sdip_back

// Takes one ASCII character per transaction on the char channel, the last one
// marked by last_char, and on that last character gives one result transaction
// with a signed 64-bit value and a status (0 ok, 1 empty, 2 invalid, 3 overflow).
// Whitespace (codes 9 to 13 and 32) around the number is skipped, one optional
// sign is allowed, the magnitude must stay within 2^(VALUE_BITS-1)-1 and the
// first error wins. Throughput is one character per cycle unless a full queue or
// a held result stalls it, set by the single multiply-by-ten-and-add step per
// character in the back end; a result is offered after its last character has
// passed the input register, the queue and the result register. A four-entry
// queue lets the input keep flowing while a result waits to be taken.

module strict_decimal_integer_parser #(
	parameter int VALUE_BITS = sdip_pkg::VALUE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  sdip_pkg::char_t char_data,
	output logic            res_valid,
	input  logic            res_stall,
	output sdip_pkg::res_t  res_data
);
	import sdip_pkg::*;

	logic q_full;
	logic push;
	cls_t push_data;
	logic pop;
	logic head_valid;
	cls_t head;

	sdip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (char_valid),
		.stall     (char_stall),
		.data      (char_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sdip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sdip_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for strict_decimal_integer_parser
// depends on sdip_pkg and the parser rtl under src; predicts every result in-line

module tb_top;

	import sdip_pkg::*;

	localparam int  CLK_HALF     = 4;
	localparam int  CYCLE_LIMIT  = 1_000_000;
	localparam int  DRAIN_CYCLES = 20;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  RANDOM_CHARS = 700;
	localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	logic  clk;
	logic  arst_n;
	logic  char_valid;
	logic  char_stall;
	char_t char_data;
	logic  res_valid;
	logic  res_stall;
	res_t  res_data;

	res_t            expected_numbers[$];
	logic [7:0]      text_buf[$];
	int              error_count;
	int              cycle_count;
	bit              no_idle;
	bit              hold_req;

	phase_t          num_phase;
	logic            num_neg;
	logic [63:0]     num_mag;
	status_t         num_err;

	strict_decimal_integer_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// running parse of the current string
	function automatic void clear_number();
		num_phase = PH_LEAD;
		num_neg   = 1'b0;
		num_mag   = '0;
		num_err   = ST_OK;
	endfunction

	function automatic void push_digit(logic [7:0] c);
		logic [63:0] d;
		d = 64'(c - CH_ZERO);
		if (num_mag > (MAG_LIMIT - d) / 10)
			num_err = ST_OVERFLOW;
		else
			num_mag = num_mag * 10 + d;
	endfunction

	function automatic void scan_char(logic [7:0] c);
		bit ws;
		bit dig;
		ws  = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
		dig = c >= CH_ZERO && c <= CH_NINE;
		if (num_err != ST_OK)
			return;
		case (num_phase)
			PH_LEAD: begin
				if (ws) begin
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					num_neg   = (c == CH_MINUS);
					num_phase = PH_SIGN;
				end else if (dig) begin
					num_phase = PH_DIGITS;
					push_digit(c);
				end else begin
					num_err = ST_INVALID;
				end
			end
			PH_SIGN: begin
				if (dig) begin
					num_phase = PH_DIGITS;
					push_digit(c);
				end else begin
					num_err = ST_INVALID;
				end
			end
			PH_DIGITS: begin
				if (dig)
					push_digit(c);
				else if (ws)
					num_phase = PH_TRAIL;
				else
					num_err = ST_INVALID;
			end
			default: begin
				if (!ws)
					num_err = ST_INVALID;
			end
		endcase
	endfunction

	function automatic res_t close_number();
		res_t    r;
		status_t st;
		if (num_err != ST_OK)
			st = num_err;
		else if (num_phase == PH_LEAD)
			st = ST_EMPTY;
		else if (num_phase == PH_SIGN)
			st = ST_INVALID;
		else
			st = ST_OK;
		r.parse_status = st;
		r.parsed_value = '0;
		if (st == ST_OK)
			r.parsed_value = num_neg ? -num_mag : num_mag;
		clear_number();
		return r;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// text generation
	function automatic void append_char(logic [7:0] c);
		text_buf.insert(text_buf.size(), c);
	endfunction

	function automatic logic [7:0] pick_ws();
		int r;
		r = $urandom_range(CH_TAB, CH_CR + 1);
		return (r == CH_CR + 1) ? CH_SPACE : 8'(r);
	endfunction

	function automatic logic [7:0] pick_sign();
		return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
	endfunction

	function automatic void add_ws(int n);
		repeat (n) append_char(pick_ws());
	endfunction

	function automatic void add_digits(int n);
		repeat (n) append_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void add_number();
		string edge_txt;
		int    kind;
		edge_txt = "92233720368547758";
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 2) != 0)
			append_char(pick_sign());
		if (kind < 8) begin
			add_digits($urandom_range(1, 18));
		end else if (kind == 8) begin
			for (int i = 0; i < edge_txt.len(); i++)
				append_char(edge_txt[i]);
			add_digits(2);
		end else begin
			add_digits($urandom_range(19, 22));
		end
	endfunction

	function automatic void build_random_text();
		int r;
		int pos;
		text_buf.delete();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			add_ws(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			add_number();
			add_ws(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		end else if (r < 88) begin
			add_ws($urandom_range(0, 2));
			add_number();
			add_ws($urandom_range(0, 2));
			pos = $urandom_range(0, text_buf.size() - 1);
			case ($urandom_range(0, 3))
				0: text_buf[pos] = 8'($urandom_range(0, 255));
				1: text_buf.insert(pos, pick_ws());
				2: text_buf.insert(pos, pick_sign());
				default: begin
					add_ws(1);
					append_char($urandom_range(0, 1) ? pick_sign() : CH_ZERO);
				end
			endcase
		end else if (r < 91) begin
			add_ws($urandom_range(1, 4));
		end else if (r < 94) begin
			add_ws($urandom_range(0, 1));
			append_char(pick_sign());
			add_ws($urandom_range(0, 2));
		end else begin
			repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(0, 255)));
		end
	endfunction

	// one char transaction, prediction taken at acceptance
	task automatic send_char(logic [7:0] c, logic last);
		char_t item;
		int    gap;
		item.char_code = c;
		item.last_char = last;
		char_valid <= 1'b1;
		char_data  <= item;
		do @(posedge clk); while (char_stall);
		scan_char(c);
		if (last)
			expected_numbers.insert(expected_numbers.size(), close_number());
		gap = no_idle ? 0 : idle_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_buffer();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_text(string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			append_char(s[i]);
		send_buffer();
	endtask

	// tests
	task automatic test_directed_cases();
		string cases[] = '{
			" ", "\t\n\013\014\r ", "0", "+0", "-0007",
			"9223372036854775807", "-9223372036854775807",
			"9223372036854775808", "-9223372036854775808",
			"+", "- ", "-\t5", "12a", "1 2", " \r42\n ",
			"\200", "\3771", "7-", "+-3",
			"99999999999999999999x", "x9", " +1234567890 "
		};
		foreach (cases[i])
			send_text(cases[i]);
	endtask

	task automatic test_random_strings();
		int sent;
		sent = 0;
		while (sent < RANDOM_CHARS) begin
			build_random_text();
			sent += text_buf.size();
			send_buffer();
		end
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (40) begin
			build_random_text();
			send_buffer();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_result_backpressure();
		hold_req = 1'b1;
		repeat (60) begin
			text_buf.delete();
			add_digits($urandom_range(1, 2));
			send_buffer();
		end
	endtask

	// result side stall
	initial begin
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left   = 0;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (no_idle) begin
				res_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if (run_left > 0) begin
					run_left--;
				end else begin
					stall_left = idle_gap();
					run_left   = $urandom_range(0, 20);
				end
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_numbers.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: value %0d status %0d",
						res_data.parsed_value, res_data.parse_status);
			end else begin
				want = expected_numbers.pop_front();
				if (res_data.parsed_value !== want.parsed_value ||
					res_data.parse_status !== want.parse_status) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected value %0d status %0d, got value %0d status %0d",
							want.parsed_value, want.parse_status,
							res_data.parsed_value, res_data.parse_status);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		error_count = 0;
		no_idle     = 1'b0;
		hold_req    = 1'b0;
		clear_number();
		arst_n     <= 1'b0;
		char_valid <= 1'b0;
		char_data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_strings();
		test_back_to_back();
		test_result_backpressure();
		test_random_strings();
		char_valid <= 1'b0;
		wait (expected_numbers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_numbers.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
